// ===== hdl/sqlm_pkg.sv =====
`default_nettype none

package sqlm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int POS_W       = $clog2(PATTERN_MAX + 1);
  localparam int UNIT_W      = 16;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  localparam logic [UNIT_W-1:0] UNIT_ONE   = 16'h005F;
  localparam logic [UNIT_W-1:0] UNIT_ANY   = 16'h0025;
  localparam logic [UNIT_W-1:0] FOLD_LO    = 16'h0061;
  localparam logic [UNIT_W-1:0] FOLD_HI    = 16'h007A;
  localparam logic [UNIT_W-1:0] FOLD_DELTA = 16'h0020;

  localparam logic [APB_AW-1:0] ADDR_ESCAPE = 3'd0;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_APPEND  = 2'd1,
    REQ_SUBJECT = 2'd2,
    REQ_END     = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_LIT = 2'd0,
    KIND_ONE = 2'd1,
    KIND_ANY = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [UNIT_W-1:0] unit;
  } entry_t;

  typedef struct packed {
    req_type_e         req_type;
    logic [UNIT_W-1:0] code_unit;
  } item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } result_t;

  function automatic logic [UNIT_W-1:0] fold_unit(input logic [UNIT_W-1:0] u);
    return (u >= FOLD_LO && u <= FOLD_HI) ? u - FOLD_DELTA : u;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sqlm_cfg.sv =====
`default_nettype none

module sqlm_cfg
  import sqlm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output logic      [UNIT_W-1:0] escape_unit_o
);

  logic [UNIT_W-1:0] esc_q;
  logic [UNIT_W-1:0] esc_d;
  logic              wr_en;
  logic              sel_esc;

  assign pready  = 1'b1;
  assign sel_esc = (paddr[APB_AW-1:2] == ADDR_ESCAPE[APB_AW-1:2]);
  assign wr_en   = psel && penable && pwrite && sel_esc;

  always_comb begin
    esc_d = esc_q;
    if (wr_en) begin
      esc_d = pwdata[UNIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= '0;
    end else begin
      esc_q <= esc_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_esc) begin
      prdata = {{(APB_DW-UNIT_W){1'b0}}, esc_q};
    end
  end

  assign escape_unit_o = esc_q;

endmodule

`default_nettype wire

// ===== hdl/sqlm_core.sv =====
`default_nettype none

module sqlm_core
  import sqlm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire item_t             item_i,
  input  wire logic [UNIT_W-1:0] escape_unit_i,
  output logic                   res_valid_o,
  output result_t                res_o
);

  entry_t               store_q [PATTERN_MAX];
  logic [POS_W-1:0]     len_q, len_d;
  logic                 pend_q, pend_d;
  logic                 ovf_q, ovf_d;
  logic [PATTERN_MAX:0] act_q, act_d;

  logic                 put_a_v, put_b_v;
  entry_t               put_a, put_b, first_e;
  logic [1:0]           put_n;
  logic [POS_W:0]       len_sum, len_p1;
  logic [POS_W-1:0]     len_new;
  logic                 ovf_set;
  logic                 rearm, step, finish, clear;
  logic [UNIT_W-1:0]    unit_f;
  logic                 we [PATTERN_MAX];
  entry_t               eff [PATTERN_MAX];
  logic [PATTERN_MAX:0] live, anym, base, gen, closed, nxt;
  logic [PATTERN_MAX+1:0] csum, carries;

  assign unit_f = fold_unit(item_i.code_unit);

  always_comb begin
    put_a_v = 1'b0;
    put_b_v = 1'b0;
    put_a   = '{kind: KIND_LIT, unit: fold_unit(escape_unit_i)};
    put_b   = '{kind: KIND_LIT, unit: unit_f};
    pend_d  = pend_q;
    rearm   = 1'b0;
    step    = 1'b0;
    finish  = 1'b0;
    clear   = 1'b0;
    unique case (item_i.req_type)
      REQ_CLEAR: begin
        clear  = 1'b1;
        pend_d = 1'b0;
        rearm  = 1'b1;
      end
      REQ_APPEND: begin
        rearm  = 1'b1;
        pend_d = 1'b0;
        if (pend_q && (item_i.code_unit == UNIT_ONE || item_i.code_unit == UNIT_ANY)) begin
          put_b_v = 1'b1;
          put_b   = '{kind: KIND_LIT, unit: item_i.code_unit};
        end else begin
          put_a_v = pend_q;
          if (item_i.code_unit == UNIT_ONE) begin
            put_b_v = 1'b1;
            put_b   = '{kind: KIND_ONE, unit: '0};
          end else if (item_i.code_unit == UNIT_ANY) begin
            put_b_v = 1'b1;
            put_b   = '{kind: KIND_ANY, unit: '0};
          end else if (escape_unit_i != '0 && item_i.code_unit == escape_unit_i) begin
            pend_d = 1'b1;
          end else begin
            put_b_v = 1'b1;
          end
        end
      end
      REQ_SUBJECT: begin
        put_a_v = pend_q;
        pend_d  = 1'b0;
        step    = 1'b1;
      end
      REQ_END: begin
        put_a_v = pend_q;
        pend_d  = 1'b0;
        finish  = 1'b1;
        rearm   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // up to two new entries: pending escape literal, then the unit itself
  assign put_n   = {1'b0, put_a_v} + {1'b0, put_b_v};
  assign first_e = put_a_v ? put_a : put_b;
  assign len_sum = {1'b0, len_q} + {{(POS_W-1){1'b0}}, put_n};
  assign len_p1  = {1'b0, len_q} + {{POS_W{1'b0}}, 1'b1};
  assign ovf_set = len_sum > (POS_W+1)'(PATTERN_MAX);
  assign len_new = ovf_set ? POS_W'(PATTERN_MAX) : len_sum[POS_W-1:0];

  always_comb begin
    anym = '0;
    live = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      we[i]  = 1'b0;
      eff[i] = store_q[i];
      if ((POS_W+1)'(i) == {1'b0, len_q} && put_n != 2'd0) begin
        we[i]  = 1'b1;
        eff[i] = first_e;
      end else if ((POS_W+1)'(i) == len_p1 && put_n == 2'd2) begin
        we[i]  = 1'b1;
        eff[i] = put_b;
      end
      live[i] = (POS_W+1)'(i) < {1'b0, len_new};
      anym[i] = live[i] && (eff[i].kind == KIND_ANY);
    end
  end

  // epsilon closure through runs of '%' as one carry chain
  assign base    = pend_q ? {{PATTERN_MAX{1'b0}}, 1'b1} : act_q;
  assign gen     = base & anym;
  assign csum    = {1'b0, anym} + {1'b0, gen};
  assign carries = csum ^ {1'b0, anym} ^ {1'b0, gen};
  assign closed  = base | carries[PATTERN_MAX:0];

  always_comb begin
    nxt = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (closed[i] && live[i]) begin
        case (eff[i].kind)
          KIND_ANY: nxt[i]   = 1'b1;
          KIND_ONE: nxt[i+1] = 1'b1;
          KIND_LIT: nxt[i+1] = nxt[i+1] | (eff[i].unit == unit_f);
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    act_d = act_q;
    if (fire_i) begin
      len_d = clear ? '0 : len_new;
      ovf_d = clear ? 1'b0 : (ovf_q | ovf_set);
      if (rearm) begin
        act_d = {{PATTERN_MAX{1'b0}}, 1'b1};
      end else if (step) begin
        act_d = nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      pend_q <= 1'b0;
      ovf_q  <= 1'b0;
      act_q  <= {{PATTERN_MAX{1'b0}}, 1'b1};
    end else begin
      len_q  <= len_d;
      pend_q <= fire_i ? pend_d : pend_q;
      ovf_q  <= ovf_d;
      act_q  <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (fire_i && we[i]) begin
        store_q[i] <= eff[i];
      end
    end
  end

  assign res_valid_o          = fire_i && finish;
  assign res_o.matched        = closed[len_new];
  assign res_o.pattern_overflow = ovf_q | ovf_set;

`ifndef SYNTH
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= POS_W'(PATTERN_MAX))
    else $error("pattern length beyond capacity");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.req_type == REQ_CLEAR |=> len_q == '0 && !ovf_q && !pend_q)
    else $error("clear did not empty the pattern");

  a_pend_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pend_q) |-> $past(fire_i && item_i.req_type == REQ_APPEND))
    else $error("escape pending without append");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> len_q == POS_W'(PATTERN_MAX))
    else $error("overflow flagged while pattern not full");
`endif

endmodule

`default_nettype wire

// ===== hdl/sql_like_wildcard_matcher.sv =====
// Case-insensitive SQL LIKE matcher with a 32-entry pattern store.
// Input channel (in_valid_i/in_ready_o) carries req_type_i and code_unit_i:
// clear pattern, append pattern unit, subject unit, end of subject.
// Only end-of-subject items give a result on the output channel
// (out_valid_o/out_ready_i): matched_o and pattern_overflow_o.
// The escape unit is written through the APB port at address 0 (zero = off);
// write it only while the block is idle.
// Timing: an item is registered on acceptance and processed when it leaves that
// register, by one pass through the NFA update (one 33-bit carry chain for the '%'
// closure plus 32 parallel unit compares); an end item's result is registered in
// the output register behind out_valid_o. One item per cycle is sustained while
// in_ready_o is high. When the receiver stalls, the output register holds the result;
// pattern and subject items keep flowing, and in_ready_o drops only when an end item
// waits behind an unaccepted result.
// Reset empties the pattern, clears the escape and overflow state and rearms
// the NFA; the escape register resets to zero.
`default_nettype none

module sql_like_wildcard_matcher
  import sqlm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [UNIT_W-1:0] code_unit_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   matched_o,
  output logic                   pattern_overflow_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  logic              s1_v_q, s1_v_d;
  item_t             s1_q;
  logic              out_v_q, out_v_d;
  result_t           out_q;
  logic              out_free, s1_go, in_fire;
  logic              res_v;
  result_t           res;
  logic [UNIT_W-1:0] esc;

  sqlm_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .escape_unit_o (esc)
  );

  assign out_free   = !out_v_q || out_ready_i;
  assign s1_go      = s1_v_q && (s1_q.req_type != REQ_END || out_free);
  assign in_ready_o = !s1_v_q || s1_go;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_v_d = s1_v_q;
    if (in_fire) begin
      s1_v_d = 1'b1;
    end else if (s1_go) begin
      s1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.req_type  <= req_type_e'(req_type_i);
      s1_q.code_unit <= code_unit_i;
    end
  end

  sqlm_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (s1_go),
    .item_i        (s1_q),
    .escape_unit_i (esc),
    .res_valid_o   (res_v),
    .res_o         (res)
  );

  always_comb begin
    out_v_d = out_v_q;
    if (res_v) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_v) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_v_q;
  assign matched_o          = out_q.matched;
  assign pattern_overflow_o = out_q.pattern_overflow;

endmodule

`default_nettype wire
